[src/tpag_pkg.sv]
// Shared types and constants for the tensor permute address generator.
// No dependencies; imported by every module of the block.
package tpag_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM = 4'd2;

  // Fixed register field widths.
  localparam int RANK_REG_W   = 4;
  localparam int DIMS_REG_W   = 64;
  localparam int PERM_REG_W   = 24;
  localparam int PERM_FIELD_W = 3;

  // Setup sequencer states.
  typedef enum logic [1:0] {
    S_INIT,
    S_COEF,
    S_DELTA,
    S_RUN
  } setup_state_e;

  // Control broadcast from the setup sequencer to the row of axis cells.
  typedef struct packed {
    logic                    clear_cnt;
    logic                    clear_stride;
    logic                    acc_en;
    logic                    dlt_en;
    logic [PERM_FIELD_W-1:0] axis;
  } setup_ctrl_t;

endpackage

[src/tpag_cell.sv]
// One axis cell of the counter chain: digit counter, stride and step delta.
// Depends on tpag_pkg for the setup control struct.
module tpag_cell #(
  parameter int AXIS       = 0,
  parameter int DIM_BITS   = 8,
  parameter int INDEX_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tpag_pkg::setup_ctrl_t  ctrl_i,
  input  logic [INDEX_BITS-1:0]  wdata_i,
  input  logic                   active_i,
  input  logic [DIM_BITS-1:0]    size_i,
  input  logic                   step_i,
  input  logic                   carry_i,
  output logic                   carry_o,
  output logic                   hit_o,
  output logic [INDEX_BITS-1:0]  delta_o,
  output logic [INDEX_BITS-1:0]  stride_o
);
  import tpag_pkg::*;

  logic [DIM_BITS-1:0]   cnt_q, cnt_d;
  logic [INDEX_BITS-1:0] stride_q, delta_q;
  logic                  not_max;
  logic                  sel;

  // The digit can still step when it is below its last value.
  assign not_max = ({1'b0, cnt_q} + {{DIM_BITS{1'b0}}, 1'b1}) < {1'b0, size_i};
  assign sel     = (ctrl_i.axis == PERM_FIELD_W'(AXIS));

  // Carry ripples toward axis 0; unused axes pass it straight on.
  assign carry_o  = active_i ? (carry_i && !not_max) : carry_i;
  assign hit_o    = step_i && active_i && carry_i && not_max;
  assign delta_o  = hit_o ? delta_q : '0;
  assign stride_o = stride_q;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clear_cnt) begin
      cnt_d = '0;
    end else if (step_i && active_i && carry_i) begin
      cnt_d = not_max ? cnt_q + DIM_BITS'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Stride and delta are filled by the setup sequencer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear_stride) begin
      stride_q <= '0;
    end else if (ctrl_i.acc_en && sel) begin
      stride_q <= stride_q + wdata_i;
    end
    if (ctrl_i.dlt_en && sel) begin
      delta_q <= wdata_i;
    end
  end

endmodule

[src/tpag_setup.sv]
// Setup sequencer: derives per-axis strides and step deltas after a config write.
// Depends on tpag_pkg; drives the control broadcast of the tpag_cell row.
module tpag_setup #(
  parameter int MAX_RANK   = 8,
  parameter int DIM_BITS   = 8,
  parameter int INDEX_BITS = 32,
  parameter int RANK_W     = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RANK_W-1:0]      rank_i,
  input  logic [tpag_pkg::PERM_REG_W-1:0] perm_i,
  input  logic [DIM_BITS-1:0]    size_i   [MAX_RANK],
  input  logic [INDEX_BITS-1:0]  stride_i [MAX_RANK],
  output logic                   busy_o,
  output tpag_pkg::setup_ctrl_t  ctrl_o,
  output logic [INDEX_BITS-1:0]  wdata_o
);
  import tpag_pkg::*;

  localparam int AXW = $clog2(MAX_RANK);

  setup_state_e            state_q, state_d;
  logic [AXW-1:0]          d_q;
  logic [INDEX_BITS-1:0]   coef_q, acc_q;
  logic [PERM_FIELD_W-1:0] pf [MAX_RANK];
  logic [PERM_FIELD_W-1:0] cur_pf;
  logic                    axis_ok;
  logic [DIM_BITS-1:0]     tsize;
  logic [DIM_BITS-1:0]     ksize_m1;
  logic [INDEX_BITS-1:0]   stride_k;
  logic [AXW-1:0]          top_axis;

  // Split the permutation register into its fields.
  for (genvar i = 0; i < MAX_RANK; i++) begin : g_pf
    assign pf[i] = perm_i[PERM_FIELD_W*i +: PERM_FIELD_W];
  end

  assign top_axis = AXW'(rank_i - RANK_W'(1));
  assign cur_pf   = pf[d_q];
  assign axis_ok  = 4'(cur_pf) < 4'(rank_i);
  assign tsize    = axis_ok ? size_i[cur_pf[AXW-1:0]] : DIM_BITS'(1);
  assign stride_k = stride_i[d_q];
  assign ksize_m1 = size_i[d_q] - DIM_BITS'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:  state_d = S_COEF;
      S_COEF:  if (d_q == '0) state_d = S_DELTA;
      S_DELTA: if (d_q == '0) state_d = S_RUN;
      S_RUN:   state_d = S_RUN;
      default: state_d = S_INIT;
    endcase
    if (start_i) begin
      state_d = S_INIT;
    end
  end

  // Outputs to the cell row.
  always_comb begin
    ctrl_o           = '0;
    wdata_o          = '0;
    ctrl_o.clear_cnt = start_i;
    case (state_q)
      S_INIT: begin
        ctrl_o.clear_stride = 1'b1;
      end
      S_COEF: begin
        ctrl_o.acc_en = axis_ok;
        ctrl_o.axis   = cur_pf;
        wdata_o       = coef_q;
      end
      S_DELTA: begin
        ctrl_o.dlt_en = 1'b1;
        ctrl_o.axis   = PERM_FIELD_W'(d_q);
        wdata_o       = stride_k - acc_q;
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != S_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Step counter, running target coefficient and delta accumulator.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_INIT: begin
        d_q    <= top_axis;
        coef_q <= INDEX_BITS'(1);
        acc_q  <= '0;
      end
      S_COEF: begin
        coef_q <= INDEX_BITS'(coef_q * tsize);
        d_q    <= (d_q == '0) ? top_axis : d_q - AXW'(1);
      end
      S_DELTA: begin
        acc_q <= acc_q + INDEX_BITS'(stride_k * ksize_m1);
        d_q   <= d_q - AXW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

[src/tensor_permute_address_gen_core.sv]
// Tensor axis permutation address generator: top level.
// Depends on tpag_pkg, tpag_setup and tpag_cell.
//
// Source elements enter on the in_* channel in row-major source order; each
// request produces one result on the out_* channel carrying the element, its
// row-major index in the permuted target tensor and a last flag on the final
// element, after which the source coordinate wraps to zero.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. Each accepted request is registered in an output register backed
// by a one-entry skid buffer, so one element per cycle is sustained while
// the receiver keeps up and no setup pass runs. When the receiver stalls, the
// skid entry takes one more request and then in_stall_o rises.
// Each axis has a cell in a carry chain; the cell that steps supplies a
// precomputed index delta, so an element costs one add per cycle.
// Reset and every write to a known register (cfg_valid_i & cfg_ready_o) clear
// the coordinate and run a setup pass (an init step, a coefficient pass, then
// a delta pass over the active axes) that rebuilds the strides; in_stall_o is
// high during it. cfg_ready_o is always high. Writes to indexes past the register list are ignored.
module tensor_permute_address_gen_core #(
  parameter int MAX_RANK   = 8,
  parameter int DIM_BITS   = 8,
  parameter int INDEX_BITS = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tpag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [VALUE_BITS-1:0]            element_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [INDEX_BITS-1:0]            target_index_o,
  output logic [VALUE_BITS-1:0]            element_out_o,
  output logic                             last_element_o
);
  import tpag_pkg::*;

  localparam int RANK_W = $clog2(MAX_RANK + 1);
  localparam int PAD_W  = (MAX_RANK * DIM_BITS > DIMS_REG_W) ? MAX_RANK * DIM_BITS : DIMS_REG_W;

  logic [RANK_REG_W-1:0] rank_q;
  logic [DIMS_REG_W-1:0] dims_q;
  logic [PERM_REG_W-1:0] perm_q;
  logic                  cfg_we, cfg_start;

  logic [RANK_W-1:0]     eff_rank;
  logic [PAD_W-1:0]      dims_pad;
  logic [DIM_BITS-1:0]   size   [MAX_RANK];
  logic                  active [MAX_RANK];
  logic [INDEX_BITS-1:0] stride [MAX_RANK];
  logic [INDEX_BITS-1:0] delta  [MAX_RANK];
  logic [MAX_RANK-1:0]   hit;
  logic [MAX_RANK:0]     carry;

  setup_ctrl_t           ctrl;
  logic [INDEX_BITS-1:0] wdata;
  logic                  busy;

  logic                  accept, wrap, out_free;
  logic [INDEX_BITS-1:0] delta_sum;
  logic [INDEX_BITS-1:0] idx_q;

  logic                  out_valid_q, skid_valid_q;
  logic [INDEX_BITS-1:0] out_index_q, skid_index_q;
  logic [VALUE_BITS-1:0] out_value_q, skid_value_q;
  logic                  out_last_q, skid_last_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_start   = cfg_we && ((cfg_index_i == CFG_RANK) || (cfg_index_i == CFG_DIMS) ||
                                  (cfg_index_i == CFG_PERM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_REG_W'(1);
      dims_q <= DIMS_REG_W'(1);
      perm_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_RANK: rank_q <= cfg_data_i[RANK_REG_W-1:0];
        CFG_DIMS: dims_q <= cfg_data_i[DIMS_REG_W-1:0];
        CFG_PERM: perm_q <= cfg_data_i[PERM_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective rank: zero counts as one, large values saturate.
  always_comb begin
    if (rank_q == '0) begin
      eff_rank = RANK_W'(1);
    end else if (rank_q > RANK_REG_W'(MAX_RANK)) begin
      eff_rank = RANK_W'(MAX_RANK);
    end else begin
      eff_rank = RANK_W'(rank_q);
    end
  end

  // Axis sizes; a zero field or a field past the register counts as one.
  assign dims_pad = PAD_W'(dims_q);
  for (genvar a = 0; a < MAX_RANK; a++) begin : g_size
    logic [DIM_BITS-1:0] field;
    assign field     = dims_pad[a*DIM_BITS +: DIM_BITS];
    assign size[a]   = (field == '0) ? DIM_BITS'(1) : field;
    assign active[a] = RANK_W'(a) < eff_rank;
  end

  tpag_setup #(
    .MAX_RANK   (MAX_RANK),
    .DIM_BITS   (DIM_BITS),
    .INDEX_BITS (INDEX_BITS),
    .RANK_W     (RANK_W)
  ) u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_start),
    .rank_i   (eff_rank),
    .perm_i   (perm_q),
    .size_i   (size),
    .stride_i (stride),
    .busy_o   (busy),
    .ctrl_o   (ctrl),
    .wdata_o  (wdata)
  );

  // Cell chain: carry enters at the innermost axis and ripples to axis 0.
  assign carry[MAX_RANK] = 1'b1;
  for (genvar a = 0; a < MAX_RANK; a++) begin : g_cell
    tpag_cell #(
      .AXIS       (a),
      .DIM_BITS   (DIM_BITS),
      .INDEX_BITS (INDEX_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wdata_i  (wdata),
      .active_i (active[a]),
      .size_i   (size[a]),
      .step_i   (accept),
      .carry_i  (carry[a+1]),
      .carry_o  (carry[a]),
      .hit_o    (hit[a]),
      .delta_o  (delta[a]),
      .stride_o (stride[a])
    );
  end

  assign wrap = carry[0];

  always_comb begin
    delta_sum = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      delta_sum = delta_sum | delta[a];
    end
  end

  // Running target index of the next element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cfg_start) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= wrap ? '0 : idx_q + delta_sum;
    end
  end

  // Input handshake: stall during setup or when the skid entry is full.
  assign in_stall_o = busy || skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Output register and skid entry control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q && !out_stall_i) begin
      out_index_q <= skid_index_q;
      out_value_q <= skid_value_q;
      out_last_q  <= skid_last_q;
    end else if (accept && out_free) begin
      out_index_q <= idx_q;
      out_value_q <= element_value_i;
      out_last_q  <= wrap;
    end
    if (accept && !out_free) begin
      skid_index_q <= idx_q;
      skid_value_q <= element_value_i;
      skid_last_q  <= wrap;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_index_o = out_index_q;
  assign element_out_o  = out_value_q;
  assign last_element_o = out_last_q;

`ifndef SYNTHESIS
  // At most one cell takes the step on any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit))
    else $error("more than one axis cell stepped");

  // An accepted element either steps exactly one axis or wraps the tensor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (wrap != (|hit)))
    else $error("step and wrap disagree");

  // The skid entry is only used behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A register write always restarts the setup pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_start |=> busy)
    else $error("setup not restarted after configuration write");
`endif

endmodule

[tb/sv/tb_tensor_permute_address_gen_core.sv]
// Self-checking testbench for tensor_permute_address_gen_core: streams source elements through
// many tensor shapes and axis permutations and checks each target index, element and last flag.
// Depends on tpag_pkg and the tensor_permute_address_gen_core RTL.
module tb_tensor_permute_address_gen_core;
  import tpag_pkg::*;

  localparam int MAX_RANK    = 8;
  localparam int DIM_BITS    = 8;
  localparam int INDEX_BITS  = 32;
  localparam int VALUE_BITS  = 64;
  localparam int ITEM_GOAL   = 1750;
  localparam int CALM_TAIL   = 150;
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  // Highest index the configuration port can carry; everything past CFG_PERM is unused.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

  typedef enum logic [1:0] {
    REQ_ELEM,
    REQ_CFG,
    REQ_DRAIN
  } req_kind_e;

  typedef struct packed {
    req_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] target;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] element_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [INDEX_BITS-1:0] target_index_o;
  logic [VALUE_BITS-1:0] element_out_o;
  logic                  last_element_o;

  tensor_permute_address_gen_core #(
    .MAX_RANK  (MAX_RANK),
    .DIM_BITS  (DIM_BITS),
    .INDEX_BITS(INDEX_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .target_index_o (target_index_o),
    .element_out_o  (element_out_o),
    .last_element_o (last_element_o)
  );

  request_t request_q [$];
  result_t  results_q [$];

  int unsigned elem_total = 0;
  int unsigned elems_sent = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stuck_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  logic [7:0]  phase_cyc = '0;
  logic        idle_mode = 1'b0;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        calm;

  // Idling stops for the final stretch of elements.
  assign calm = (elems_sent + CALM_TAIL >= elem_total);

  // Own copy of the configuration registers and of the address state.
  logic [RANK_REG_W-1:0] rank_q;
  logic [DIMS_REG_W-1:0] dims_q;
  logic [PERM_REG_W-1:0] perm_q;
  logic [DIM_BITS-1:0]   coord_q [MAX_RANK];
  logic [INDEX_BITS-1:0] next_target_q;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_elem(input logic [VALUE_BITS-1:0] value);
    request_q.push_back('{kind: REQ_ELEM, index: '0, data: value});
    elem_total++;
  endfunction

  function automatic void push_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    request_q.push_back('{kind: REQ_CFG, index: idx, data: data});
  endfunction

  function automatic void push_drain();
    request_q.push_back('{kind: REQ_DRAIN, index: '0, data: '0});
  endfunction

  // Rank zero counts as one and anything above MAX_RANK saturates.
  function automatic int unsigned active_rank();
    if (rank_q == '0) return 1;
    if (rank_q > MAX_RANK) return MAX_RANK;
    return 32'(rank_q);
  endfunction

  // Axes at or above the rank, and zero-sized fields, have extent one.
  function automatic int unsigned axis_extent(input int unsigned axis, input int unsigned rank);
    int unsigned sz;
    if (axis >= rank) return 1;
    sz = 32'(dims_q[axis*DIM_BITS +: DIM_BITS]);
    return (sz == 0) ? 1 : sz;
  endfunction

  function automatic void clear_coordinate();
    for (int a = 0; a < MAX_RANK; a++) coord_q[a] = '0;
    next_target_q = '0;
  endfunction

  // Returns the result for one element and steps the source coordinate.
  function automatic result_t predict_result(input logic [VALUE_BITS-1:0] value);
    result_t                 res;
    int unsigned             rank;
    logic [INDEX_BITS-1:0]   weight [MAX_RANK];
    logic [INDEX_BITS-1:0]   stride [MAX_RANK];
    logic [PERM_FIELD_W-1:0] src;
    logic                    carry;
    rank = active_rank();
    res.target = next_target_q;
    res.value = value;
    // Row-major weights of the target axes, wrapped to the index width.
    weight[rank-1] = INDEX_BITS'(1);
    for (int d = rank - 1; d > 0; d--) begin
      weight[d-1] = INDEX_BITS'(weight[d] *
                    axis_extent(perm_q[d*PERM_FIELD_W +: PERM_FIELD_W], rank));
    end
    // A source axis moves the target index by the sum of the weights that name it.
    for (int a = 0; a < MAX_RANK; a++) stride[a] = '0;
    for (int d = 0; d < rank; d++) begin
      src = perm_q[d*PERM_FIELD_W +: PERM_FIELD_W];
      if (src < rank) stride[src] = stride[src] + weight[d];
    end
    // Mixed-radix increment, last axis fastest.
    carry = 1'b1;
    for (int a = rank - 1; a >= 0 && carry; a--) begin
      if (coord_q[a] + 1 < axis_extent(a, rank)) begin
        coord_q[a] = coord_q[a] + 1'b1;
        next_target_q = next_target_q + stride[a];
        carry = 1'b0;
      end else begin
        next_target_q = next_target_q - coord_q[a] * stride[a];
        coord_q[a] = '0;
      end
    end
    if (carry) clear_coordinate();
    res.last = carry;
    return res;
  endfunction

  // Request driver: takes the next request from the queue and holds it until accepted.
  always @(negedge clk_i) begin : drive_requests
    request_t              req;
    logic                  nxt_valid;
    logic [VALUE_BITS-1:0] nxt_value;
    logic                  nxt_cfg_valid;
    logic [CFG_IDX_W-1:0]  nxt_index;
    logic [CFG_DATA_W-1:0] nxt_data;
    logic                  quiet;
    nxt_valid = in_valid_i;
    nxt_value = element_value_i;
    nxt_cfg_valid = cfg_valid_i;
    nxt_index = cfg_index_i;
    nxt_data = cfg_data_i;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_taken) nxt_cfg_valid = 1'b0;
      if (in_valid_i && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid && !nxt_cfg_valid && request_q.size() != 0) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (idle_mode && !calm && $urandom_range(0, 15) == 0) begin
          in_gap <= $urandom_range(0, 16);
        end else begin
          req = request_q[0];
          // Register writes and drain points wait until every result is out.
          quiet = (results_q.size() == 0) && !out_valid_o && !in_stall_o;
          case (req.kind)
            REQ_ELEM: begin
              void'(request_q.pop_front());
              nxt_valid = 1'b1;
              nxt_value = req.data;
              elems_sent <= elems_sent + 1;
            end
            REQ_CFG: begin
              if (quiet) begin
                void'(request_q.pop_front());
                nxt_cfg_valid = 1'b1;
                nxt_index = req.index;
                nxt_data = req.data;
              end
            end
            default: begin
              if (quiet) void'(request_q.pop_front());
            end
          endcase
        end
      end
    end
    in_valid_i <= nxt_valid;
    element_value_i <= nxt_value;
    cfg_valid_i <= nxt_cfg_valid;
    cfg_index_i <= nxt_index;
    cfg_data_i <= nxt_data;
  end

  // Receiver back-pressure in random bursts.
  always @(negedge clk_i) begin : drive_stall
    if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else if (rst_ni && idle_mode && !calm && $urandom_range(0, 11) == 0) begin
      out_gap <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: checks results, tracks register writes and predicts each accepted request.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
      rank_q = RANK_REG_W'(1);
      dims_q = DIMS_REG_W'(1);
      perm_q = '0;
      clear_coordinate();
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
      // Compare each delivered result with the oldest prediction.
      if (out_valid_o && !out_stall_i) begin
        if (results_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result: index %h value %h last %b",
                                  target_index_o, element_out_o, last_element_o));
        end else begin
          want = results_q.pop_front();
          if (target_index_o !== want.target)
            note_mismatch($sformatf("target_index %h, predicted %h",
                                    target_index_o, want.target));
          if (element_out_o !== want.value)
            note_mismatch($sformatf("element_out %h, predicted %h",
                                    element_out_o, want.value));
          if (last_element_o !== want.last)
            note_mismatch($sformatf("last_element %b, predicted %b (index %h)",
                                    last_element_o, want.last, want.target));
        end
      end
      // A write to a known register starts a new tensor; unused indexes change nothing.
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RANK: begin
            rank_q = cfg_data_i[RANK_REG_W-1:0];
            clear_coordinate();
          end
          CFG_DIMS: begin
            dims_q = cfg_data_i[DIMS_REG_W-1:0];
            clear_coordinate();
          end
          CFG_PERM: begin
            perm_q = cfg_data_i[PERM_REG_W-1:0];
            clear_coordinate();
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) results_q.push_back(predict_result(element_value_i));
    end
  end

  // Watchdog on cycles with no accepted request or result; also paces the idling mode.
  always @(posedge clk_i) begin : watchdog
    phase_cyc <= phase_cyc + 1'b1;
    if (phase_cyc == '0) idle_mode <= ($urandom_range(0, 3) != 0);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("[%0t] timeout: no request accepted for %0d cycles", $time, stuck_cnt);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  initial begin : run_test
    int unsigned           code;
    int unsigned           eff;
    int unsigned           vol;
    int unsigned           sz;
    int unsigned           n;
    int unsigned           split;
    int unsigned           j;
    logic                  big;
    logic                  drain;
    logic [63:0]           dims;
    logic [63:0]           rank_data;
    logic [63:0]           perm_data;
    logic [PERM_REG_W-1:0] perm;
    logic [PERM_REG_W-1:0] reversed;
    logic [2:0]            order [MAX_RANK];
    logic [2:0]            tmp_ax;
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_IDX_W-1:0]  tmp_idx;

    for (int d = 0; d < MAX_RANK; d++) begin
      reversed[d*PERM_FIELD_W +: PERM_FIELD_W] = PERM_FIELD_W'(MAX_RANK - 1 - d);
    end

    // Reset shape is a single element, so every element is the last one.
    push_elem('0);
    push_elem('1);
    // Rank zero behaves as rank one; junk above the rank field is dropped.
    push_cfg(CFG_DIMS, 64'h3);
    rank_data = rand64();
    rank_data[3:0] = 4'h0;
    push_cfg(CFG_RANK, rank_data);
    push_elem(rand64());
    push_elem('1);
    push_elem('0);
    // Rank above the maximum saturates; zero dimensions count as one; reversed axes.
    push_cfg(CFG_RANK, 64'hF);
    push_cfg(CFG_DIMS, 64'h0002_0000_0000_0002);
    push_cfg(CFG_PERM, CFG_DATA_W'(reversed));
    for (int i = 0; i < 4; i++) push_elem(rand64());
    // Sender waits here until the pipeline is empty.
    push_drain();
    // Two target axes taken from the same source axis.
    push_cfg(CFG_RANK, 64'h2);
    push_cfg(CFG_DIMS, 64'h0203);
    push_cfg(CFG_PERM, 64'h0);
    for (int i = 0; i < 6; i++) push_elem(rand64());
    // A target axis naming a source axis beyond the rank.
    push_cfg(CFG_PERM, CFG_DATA_W'({3'd1, 3'd5}));
    for (int i = 0; i < 3; i++) push_elem(rand64());
    // Full-size dimensions wrap the index; an unused register index must not clear.
    push_cfg(CFG_RANK, 64'h8);
    push_cfg(CFG_DIMS, '1);
    push_cfg(CFG_PERM, CFG_DATA_W'(reversed));
    for (int i = 0; i < 5; i++) push_elem(rand64());
    push_cfg(CFG_IDX_LAST, rand64());
    push_elem(rand64());
    push_elem(rand64());

    // Random tensors: mostly small complete ones, some huge shapes cut short.
    while (elem_total < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0)
        code = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_RANK + 1, 15);
      else
        code = $urandom_range(1, MAX_RANK);
      eff = (code == 0) ? 1 : (code > MAX_RANK) ? MAX_RANK : code;
      big = ($urandom_range(0, 7) == 0);
      dims = rand64();
      vol = 1;
      if (!big) begin
        for (int a = 0; a < eff; a++) begin
          sz = $urandom_range(0, 4);
          if (vol * ((sz == 0) ? 1 : sz) > 48) sz = $urandom_range(0, 1);
          dims[a*DIM_BITS +: DIM_BITS] = DIM_BITS'(sz);
          vol = vol * ((sz == 0) ? 1 : sz);
        end
      end
      // Mostly a true permutation of the active axes; otherwise arbitrary fields.
      perm = PERM_REG_W'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        for (int d = 0; d < eff; d++) order[d] = 3'(d);
        for (int d = eff - 1; d > 0; d--) begin
          j = $urandom_range(0, d);
          tmp_ax = order[d];
          order[d] = order[j];
          order[j] = tmp_ax;
        end
        for (int d = 0; d < eff; d++) perm[d*PERM_FIELD_W +: PERM_FIELD_W] = order[d];
      end
      rank_data = rand64();
      rank_data[RANK_REG_W-1:0] = RANK_REG_W'(code);
      perm_data = rand64();
      perm_data[PERM_REG_W-1:0] = perm;
      // Registers are written in a random order each time.
      regs[0] = CFG_RANK;
      regs[1] = CFG_DIMS;
      regs[2] = CFG_PERM;
      for (int k = 2; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp_idx = regs[k];
        regs[k] = regs[j];
        regs[j] = tmp_idx;
      end
      for (int k = 0; k < 3; k++) begin
        push_cfg(regs[k], (regs[k] == CFG_RANK) ? rank_data :
                          (regs[k] == CFG_DIMS) ? dims : perm_data);
      end
      if ($urandom_range(0, 5) == 0)
        push_cfg(CFG_IDX_W'($urandom_range(CFG_PERM + 1, CFG_IDX_LAST)), rand64());
      n = big ? $urandom_range(10, 60) : vol * $urandom_range(1, 2) + $urandom_range(0, vol / 2);
      drain = ($urandom_range(0, 3) == 0);
      split = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
        if (drain && i == split) push_drain();
        push_elem(rand64());
      end
    end

    // Reset once, then let the driver run the queue.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid_i || cfg_valid_i || results_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (results_q.size() != 0)
      note_mismatch($sformatf("%0d predicted results never arrived", results_q.size()));
    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
src/tpag_pkg.sv
src/tpag_cell.sv
src/tpag_setup.sv
src/tensor_permute_address_gen_core.sv
tb/sv/tb_tensor_permute_address_gen_core.sv
